### sv/rbsd_pkg.sv
package rbsd_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW = 31;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned OffW = 34;
  localparam int unsigned ExcW = 32;
  localparam int unsigned SqW = 64;
  localparam int unsigned SumW = 66;
  localparam int unsigned RootW = 33;

  localparam logic [RegIdxW-1:0] RegCenterX = 3'd0;
  localparam logic [RegIdxW-1:0] RegCenterY = 3'd1;
  localparam logic [RegIdxW-1:0] RegCenterZ = 3'd2;
  localparam logic [RegIdxW-1:0] RegHalfSize = 3'd3;
  localparam logic [RegIdxW-1:0] RegCornerRadius = 3'd4;

  localparam logic [SizeW-1:0] HalfSizeReset = 31'd65536;
  localparam logic [SizeW-1:0] CornerRadiusReset = 31'd3277;

  localparam logic [1:0] RegionFace = 2'd0;
  localparam logic [1:0] RegionEdge = 2'd1;
  localparam logic [1:0] RegionCorner = 2'd2;

  typedef struct packed {
    logic [1:0] region;
    logic       face;
    logic       huge;
    logic signed [OffW:0] base;
  } rbsd_side_t;

endpackage

### sv/rbsd_isqrt.sv
module rbsd_isqrt
  import rbsd_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SumW-1:0]   radicand_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [RootW-1:0]  root_o,
  output logic [SideW-1:0]  side_o
);

  logic [RootW:0]           vld_q;
  logic [RootW:0][SumW+1:0] rem_q;
  logic [RootW:0][RootW-1:0] root_q;
  logic [RootW:0][SideW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {2'b00, radicand_i};
    root_q[0] <= '0;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_step
    localparam int unsigned Bit = RootW - 1 - s;
    logic [SumW+1:0] trial;
    logic            take;
    assign trial = ({{(SumW+2-RootW){1'b0}}, root_q[s]} << (Bit + 1))
                 | ({{(SumW+1){1'b0}}, 1'b1} << (2 * Bit));
    assign take = rem_q[s] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= take ? rem_q[s] - trial : rem_q[s];
      root_q[s+1] <= take ? (root_q[s] | (RootW'(1) << Bit)) : root_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

### sv/rounded_box_signed_distance_unit.sv
// Rounded box signed distance: one point (start with busy low) enters every cycle; busy is
// always low. The distance and region appear on distance_o and region_o, flagged by done_o,
// after five arithmetic stages (offset, sort, excess, square, sum), the square root's input
// register, a 33-stage pipelined square root, one result bit per stage, and an output register. The
// receiver cannot stall. Write configuration only while no point is in flight.
module rounded_box_signed_distance_unit
  import rbsd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [RegIdxW-1:0]       cfg_index_i,
  input  logic [DataW-1:0]         cfg_data_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] distance_o,
  output logic [1:0]               region_o
);

  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [SizeW-1:0]         hs_q, cr_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      hs_q <= HalfSizeReset;
      cr_q <= CornerRadiusReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCenterX:      cx_q <= cfg_data_i;
        RegCenterY:      cy_q <= cfg_data_i;
        RegCenterZ:      cz_q <= cfg_data_i;
        RegHalfSize:     hs_q <= cfg_data_i[SizeW-1:0];
        RegCornerRadius: cr_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [OffW-1:0] thr;
  assign thr = OffW'(signed'({1'b0, hs_q})) - OffW'(signed'({1'b0, cr_q}));

  // stage 1: absolute offsets
  logic                   v1_q;
  logic [OffW-1:0]        a1_q [3];
  logic signed [OffW-1:0] d1 [3];
  assign d1[0] = OffW'(point_x_i) - OffW'(cx_q);
  assign d1[1] = OffW'(point_y_i) - OffW'(cy_q);
  assign d1[2] = OffW'(point_z_i) - OffW'(cz_q);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= d1[i][OffW-1] ? OffW'(-d1[i]) : OffW'(d1[i]);
    end
  end

  // stage 2: sort descending
  logic            v2_q;
  logic [OffW-1:0] y2_q [3];
  logic [OffW-1:0] s0, s1, s2, t0, t1;
  always_comb begin
    t0 = (a1_q[0] < a1_q[1]) ? a1_q[1] : a1_q[0];
    t1 = (a1_q[0] < a1_q[1]) ? a1_q[0] : a1_q[1];
    s1 = (t1 < a1_q[2]) ? a1_q[2] : t1;
    s2 = (t1 < a1_q[2]) ? t1 : a1_q[2];
    s0 = (t0 < s1) ? s1 : t0;
    if (t0 < s1) s1 = t0;
  end
  always_ff @(posedge clk_i) begin
    y2_q[0] <= s0;
    y2_q[1] <= s1;
    y2_q[2] <= s2;
  end

  // stage 3: excesses, count, region
  logic                   v3_q;
  logic [ExcW-1:0]        e3_q [3];
  rbsd_side_t             sd3_q;
  logic signed [OffW:0]   ex [3];
  logic [1:0]             cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 3; i++) begin
      ex[i] = signed'({1'b0, y2_q[i]}) - (OffW+1)'(thr);
      if (!ex[i][OffW] && ex[i] != '0) cnt = cnt + 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e3_q[i] <= (i < 2 || cnt == 2'd3) ? ex[i][ExcW-1:0] : '0;
    end
    sd3_q.face   <= cnt <= 2'd1;
    sd3_q.region <= (cnt <= 2'd1) ? RegionFace : (cnt == 2'd2 ? RegionEdge : RegionCorner);
    sd3_q.huge   <= ex[0][OffW:ExcW] != '0;
    sd3_q.base   <= (cnt <= 2'd1) ? signed'({1'b0, y2_q[0]}) - (OffW+1)'(hs_q)
                                  : -(OffW+1)'(cr_q);
  end

  // stage 4: squares
  logic            v4_q;
  logic [SqW-1:0]  q4_q [3];
  rbsd_side_t      sd4_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) q4_q[i] <= SqW'(e3_q[i]) * SqW'(e3_q[i]);
    sd4_q <= sd3_q;
  end

  // stage 5: sum
  logic            v5_q;
  logic [SumW-1:0] sum5_q;
  rbsd_side_t      sd5_q;
  always_ff @(posedge clk_i) begin
    sum5_q <= SumW'(q4_q[0]) + SumW'(q4_q[1]) + SumW'(q4_q[2]);
    sd5_q  <= sd4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  logic            vr;
  logic [RootW-1:0] root;
  rbsd_side_t      sdr;

  rbsd_isqrt #(.SideW($bits(rbsd_side_t))) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v5_q),
    .radicand_i (sum5_q),
    .side_i     (sd5_q),
    .valid_o    (vr),
    .root_o     (root),
    .side_o     (sdr)
  );

  logic signed [OffW+1:0] fin;
  assign fin = (OffW+2)'(sdr.base) + (sdr.face ? '0 : (OffW+2)'({1'b0, root}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    region_o <= sdr.region;
    if (!sdr.face && sdr.huge) distance_o <= 32'sh7fffffff;
    else if (fin > (OffW+2)'(32'sh7fffffff)) distance_o <= 32'sh7fffffff;
    else if (fin < -(OffW+2)'(33'sh080000000)) distance_o <= 32'sh80000000;
    else distance_o <= fin[CoordW-1:0];
  end

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> ##(RootW+2) done_o)
    else $error("result lost in pipeline");
  a_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (region_o == RegionFace || region_o == RegionEdge || region_o == RegionCorner))
    else $error("bad region");

endmodule

### tb/rounded_box_signed_distance_unit_test.sv
module rounded_box_signed_distance_unit_test
  import rbsd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct {
    logic signed [CoordW-1:0] dval;
    logic [1:0]               region;
  } sdf_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic signed [CoordW-1:0] point_z_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [RegIdxW-1:0]       cfg_index_i = '0;
  logic [DataW-1:0]         cfg_data_i = '0;
  logic                     done_o;
  logic signed [CoordW-1:0] distance_o;
  logic [1:0]               region_o;

  point_t point_q[$];
  sdf_t   sdf_q[$];
  int     errors = 0;
  int     gap_cnt = 0;
  bit     calm = 1'b0;

  longint cx = 0, cy = 0, cz = 0;
  longint half_sz = longint'(HalfSizeReset);
  longint radius = longint'(CornerRadiusReset);

  rounded_box_signed_distance_unit uut (.*);

  always #4 clk_i = ~clk_i;

  function automatic sdf_t box_distance(point_t p);
    longint y[3];
    longint t, thr, dval;
    logic [SumW-1:0] acc, c_sq;
    logic [RootW-1:0] root, c;
    logic [ExcW-1:0] e;
    int cnt;
    sdf_t r;
    y[0] = longint'(p.x) - cx;
    y[1] = longint'(p.y) - cy;
    y[2] = longint'(p.z) - cz;
    for (int i = 0; i < 3; i++) if (y[i] < 0) y[i] = -y[i];
    if (y[0] < y[1]) begin t = y[0]; y[0] = y[1]; y[1] = t; end
    if (y[1] < y[2]) begin t = y[1]; y[1] = y[2]; y[2] = t; end
    if (y[0] < y[1]) begin t = y[0]; y[0] = y[1]; y[1] = t; end
    thr = half_sz - radius;
    cnt = 0;
    for (int i = 0; i < 3; i++) if (y[i] > thr) cnt++;
    if (cnt <= 1) begin
      dval = y[0] - half_sz;
      r.region = RegionFace;
    end else begin
      r.region = (cnt == 2) ? RegionEdge : RegionCorner;
      if (y[0] - thr >= (64'sd1 <<< 32)) begin
        dval = 64'sd2147483647;
      end else begin
        acc = '0;
        for (int i = 0; i < cnt; i++) begin
          e = ExcW'(y[i] - thr);
          acc += SumW'(e) * SumW'(e);
        end
        root = '0;
        for (int b = RootW - 1; b >= 0; b--) begin
          c = root | (RootW'(1) << b);
          c_sq = SumW'(c) * SumW'(c);
          if (c_sq <= acc) root = c;
        end
        dval = longint'(root) - radius;
      end
    end
    if (dval > 64'sd2147483647) dval = 64'sd2147483647;
    if (dval < -64'sd2147483648) dval = -64'sd2147483648;
    r.dval = CoordW'(dval);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (start && !busy) begin
        sdf_q.push_back(box_distance('{point_x_i, point_y_i, point_z_i}));
        void'(point_q.pop_front());
      end
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start <= 1'b0;
      end else if (point_q.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
        gap_cnt <= $urandom_range(0, 3);
        start <= 1'b0;
      end else if (point_q.size() > 0) begin
        start <= 1'b1;
        point_x_i <= point_q[0].x;
        point_y_i <= point_q[0].y;
        point_z_i <= point_q[0].z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sdf_q.size() == 0) begin
        $display("%0t: unexpected result distance %0d region %0d", $time, distance_o,
                 region_o);
        errors++;
      end else begin
        if (distance_o !== sdf_q[0].dval) begin
          $display("%0t: distance expected %0d actual %0d", $time, sdf_q[0].dval,
                   distance_o);
          errors++;
        end
        if (region_o !== sdf_q[0].region) begin
          $display("%0t: region expected %0d actual %0d", $time, sdf_q[0].region,
                   region_o);
          errors++;
        end
        void'(sdf_q.pop_front());
      end
    end
  end

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCenterX: cx = longint'(signed'(data));
      RegCenterY: cy = longint'(signed'(data));
      RegCenterZ: cz = longint'(signed'(data));
      RegHalfSize: half_sz = longint'(data[SizeW-1:0]);
      RegCornerRadius: radius = longint'(data[SizeW-1:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (point_q.size() > 0 || start || sdf_q.size() > 0);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord(longint c);
    longint d;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: d = longint'($urandom_range(0, 2 * 65536)) - 65536;
      default: begin
        d = half_sz + longint'($urandom_range(0, 2 * 4096)) - 4096
            - longint'($urandom_range(0, 1)) * radius;
        if ($urandom_range(0, 1)) d = -d;
      end
    endcase
    return CoordW'(c + d);
  endfunction

  task automatic push_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                            logic signed [CoordW-1:0] z);
    point_q.push_back('{x, y, z});
  endtask

  initial begin
    logic [DataW-1:0] h;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_point(0, 0, 0);
    push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_point(32'h80000000, 32'h80000000, 32'h80000000);
    push_point(32'h7fffffff, 0, 0);
    push_point(32'h80000000, 0, 0);
    push_point(0, 32'h80000000, 32'h7fffffff);
    push_point(65536, 0, 0);
    push_point(0, -70000, 0);
    push_point(70000, 70000, 0);
    push_point(70000, 0, -70000);
    push_point(70000, 70000, 70000);
    push_point(-70000, 70000, -70000);
    push_point(65000, 65000, 65000);
    push_point(62259, 62259, 0);
    push_point(62260, 62260, 0);
    push_point(62260, 62260, 62260);
    push_point(62260, 62260, 62259);
    push_point(-1, -1, -1);
    push_point(32'h7fffffff, 32'h7fffffff, 0);
    push_point(32'h80000000, 70000, 70000);
    drain();
    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: begin
          write_reg(RegCenterX, 32'h7fffffff);
          write_reg(RegCenterY, 32'h80000000);
          write_reg(RegCenterZ, 32'h7fffffff);
          write_reg(RegHalfSize, 32'h7fffffff);
          write_reg(RegCornerRadius, 0);
        end
        2: begin
          write_reg(RegCenterX, 32'h80000000);
          write_reg(RegCenterY, 32'h7fffffff);
          write_reg(RegCenterZ, 32'h80000000);
          write_reg(RegHalfSize, 0);
          write_reg(RegCornerRadius, 32'hffffffff);
        end
        3: begin
          write_reg(RegCenterX, 0);
          write_reg(RegCenterY, 0);
          write_reg(RegCenterZ, 0);
          write_reg(RegHalfSize, 4096);
          write_reg(RegCornerRadius, 70000);
        end
        4: begin
          write_reg(RegHalfSize, 32'h7fffffff);
          write_reg(RegCornerRadius, 32'h7fffffff);
        end
        default: begin
          h = $urandom_range(0, 1 << 22);
          write_reg(RegCenterX, $urandom);
          write_reg(RegCenterY, $urandom_range(0, 1 << 20) - (1 << 19));
          write_reg(RegCenterZ, $urandom);
          write_reg(RegHalfSize, h | ($urandom_range(0, 1) << 31));
          write_reg(RegCornerRadius, $urandom_range(0, 1) ? $urandom_range(0, h)
                                                            : $urandom_range(0, 2 * h));
        end
      endcase
      write_reg(RegIdxW'($urandom_range(5, 7)), $urandom);
      if (ph == 9) calm = 1'b1;
      for (int i = 0; i < 126; i++) begin
        push_point(pick_coord(cx), pick_coord(cy), pick_coord(cz));
      end
      drain();
    end
    if (errors == 0) begin
      $display("rounded_box_signed_distance_unit_test passed");
    end else begin
      $display("rounded_box_signed_distance_unit_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rounded_box_signed_distance_unit_test failed");
    $finish;
  end

endmodule

### rounded_box_signed_distance_unit.f
sv/rbsd_pkg.sv
sv/rbsd_isqrt.sv
sv/rounded_box_signed_distance_unit.sv
tb/rounded_box_signed_distance_unit_test.sv
